FILE: rtl/pga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pga_pkg;

   // Field widths fixed by the request and response formats
   localparam int PAGE_WIDTH   = 15;
   localparam int ACTION_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;

   // Defaults for the top-level parameters
   localparam int NUM_PAGES_DEF   = 32768;
   localparam int COUNT_WIDTH_DEF = 8;

   // Action codes
   localparam logic [ACTION_WIDTH-1:0] ACT_ALLOC   = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_COW     = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_ADD_REF = 2'd3;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_NO_PAGES  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_RANGE     = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_COUNT_ERR = 2'd3;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [PAGE_WIDTH-1:0]   page_index;
   } req_type;

   typedef struct packed {
      logic [PAGE_WIDTH-1:0]   result_page;
      logic [STATUS_WIDTH-1:0] status;
      logic                    copy_needed;
      logic                    page_released;
   } rsp_type;

   // Commands from the controller to the page source
   typedef struct packed {
      logic pop;
      logic push;
   } src_cmd_type;

   // Page source status back to the controller
   typedef struct packed {
      logic avail;   // a page can be taken
      logic issued;  // queried page has been handed out at least once
   } src_stat_type;

endpackage

`default_nettype wire

FILE: rtl/pga_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pga_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 15,
   parameter int DEPTH  = 32768
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pga_page_source.sv
`timescale 1ns / 1ps
`default_nettype none

module pga_page_source #(
   parameter int NUM_PAGES = pga_pkg::NUM_PAGES_DEF,
   parameter int PW        = $clog2(NUM_PAGES)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [pga_pkg::PAGE_WIDTH-1:0]  first_page,
   input  wire logic                            rd_en,
   input  wire pga_pkg::src_cmd_type            cmd,
   input  wire logic [PW-1:0]                   push_page,
   input  wire logic [PW-1:0]                   query_page,
   output pga_pkg::src_stat_type                stat,
   output logic      [PW-1:0]                   take_page
);

   localparam int WW = (PW + 1 > 16) ? PW + 1 : 16;
   localparam logic [PW-1:0] FRESH_TOP = PW'(NUM_PAGES - 1);
   localparam logic [PW:0]   STACK_FULL = (PW + 1)'(NUM_PAGES);

   logic [PW:0]   depth_ff, depth_in;
   logic [PW-1:0] fresh_ff, fresh_in;
   logic          done_ff, done_in;
   logic [PW-1:0] stack_rd;
   logic [PW-1:0] top_addr;
   logic          stack_nonempty;
   logic          fresh_ok;
   logic          push_ok;

   // top of stack is read when the request is accepted
   assign top_addr = PW'(depth_ff - (PW + 1)'(1));
   assign push_ok  = cmd.push && (depth_ff < STACK_FULL);

   pga_ram #(
      .DATA_W (PW),
      .ADDR_W (PW),
      .DEPTH  (NUM_PAGES)
   ) u_stack (
      .clock      (clock),
      .wr_en      (push_ok),
      .wr_addr    (depth_ff[PW-1:0]),
      .wr_data    (push_page),
      .rd_en      (rd_en),
      .rd_addr    (top_addr),
      .rd_data_ff (stack_rd)
   );

   // candidate page: stack first, then never-issued pages from the top down
   assign stack_nonempty = (depth_ff != '0);
   assign fresh_ok       = !done_ff && (WW'(fresh_ff) >= WW'(first_page));
   assign take_page      = stack_nonempty ? stack_rd : fresh_ff;
   assign stat.avail     = stack_nonempty || fresh_ok;
   // pages above the fresh pointer have been handed out before
   assign stat.issued    = done_ff || (query_page > fresh_ff);

   always_comb begin
      depth_in = depth_ff;
      fresh_in = fresh_ff;
      done_in  = done_ff;
      if (cmd.pop) begin
         if (stack_nonempty) begin
            depth_in = depth_ff - (PW + 1)'(1);
         end else if (fresh_ff == '0) begin
            done_in = 1'b1;
         end else begin
            fresh_in = fresh_ff - PW'(1);
         end
      end else if (push_ok) begin
         depth_in = depth_ff + (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         fresh_ff <= FRESH_TOP;
         done_ff  <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         fresh_ff <= fresh_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/page_allocator_refcount_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Response: registered from the EXEC state once the output register is free.
// Requests: a new one is taken only when idle, so not during EXEC or FIN; set by
// the registered read of the count memory and its single write port.
// Reset: synchronous; no clearing pass, pages never handed out read a count of zero
// through the fresh pointer, so requests are taken as soon as reset is released.
module page_allocator_refcount_core #(
   parameter int NUM_PAGES   = pga_pkg::NUM_PAGES_DEF,
   parameter int COUNT_WIDTH = pga_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire pga_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output pga_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [pga_pkg::PAGE_WIDTH-1:0] csr_wr_data
);

   localparam int PW = $clog2(NUM_PAGES);
   localparam int WW = (PW + 1 > 16) ? PW + 1 : 16;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   localparam logic [1:0] STATE_IDLE = 2'd0;
   localparam logic [1:0] STATE_EXEC = 2'd1;
   localparam logic [1:0] STATE_FIN  = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [pga_pkg::PAGE_WIDTH-1:0]    first_page_ff;
   logic [pga_pkg::ACTION_WIDTH-1:0]  action_ff;
   logic [pga_pkg::PAGE_WIDTH-1:0]    page_ff;
   logic [COUNT_WIDTH-1:0]            dec_cnt_ff, dec_cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pga_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   out_free;
   logic                   emit;
   logic [PW-1:0]          req_addr;
   logic [PW-1:0]          page_addr;
   logic [WW-1:0]          page_wide;
   logic                   in_range;
   logic [COUNT_WIDTH-1:0] cnt_rd;
   logic [COUNT_WIDTH-1:0] cnt;
   logic                   cnt_we;
   logic [PW-1:0]          cnt_waddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata;
   pga_pkg::src_cmd_type   src_cmd;
   pga_pkg::src_stat_type  src_stat;
   logic [PW-1:0]          take_page;

   assign req_stall = (state_ff != STATE_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_addr  = PW'(WW'(req_data.page_index));
   assign page_wide = WW'(page_ff);
   assign page_addr = page_wide[PW-1:0];
   assign in_range  = (page_wide >= WW'(first_page_ff)) && (page_wide < WW'(NUM_PAGES));

   // reference counts, read on accept
   pga_ram #(
      .DATA_W (COUNT_WIDTH),
      .ADDR_W (PW),
      .DEPTH  (NUM_PAGES)
   ) u_count (
      .clock      (clock),
      .wr_en      (cnt_we),
      .wr_addr    (cnt_waddr),
      .wr_data    (cnt_wdata),
      .rd_en      (accept),
      .rd_addr    (req_addr),
      .rd_data_ff (cnt_rd)
   );

   pga_page_source #(
      .NUM_PAGES (NUM_PAGES),
      .PW        (PW)
   ) u_source (
      .clock      (clock),
      .reset      (reset),
      .first_page (first_page_ff),
      .rd_en      (accept),
      .cmd        (src_cmd),
      .push_page  (page_addr),
      .query_page (page_addr),
      .stat       (src_stat),
      .take_page  (take_page)
   );

   // never-issued pages hold a count of zero
   assign cnt  = src_stat.issued ? cnt_rd : '0;
   assign emit = (state_ff == STATE_EXEC) && out_free;

   // request execution
   always_comb begin
      state_in     = state_ff;
      dec_cnt_in   = dec_cnt_ff;
      src_cmd      = '0;
      cnt_we       = 1'b0;
      cnt_waddr    = page_addr;
      cnt_wdata    = cnt;
      rsp_data_in  = '0;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (out_free) begin
               state_in = STATE_IDLE;
               if (action_ff == pga_pkg::ACT_ALLOC) begin
                  if (src_stat.avail) begin
                     src_cmd.pop             = 1'b1;
                     cnt_we                  = 1'b1;
                     cnt_waddr               = take_page;
                     cnt_wdata               = CNT_ONE;
                     rsp_data_in.result_page = pga_pkg::PAGE_WIDTH'(WW'(take_page));
                  end else begin
                     rsp_data_in.status = pga_pkg::STAT_NO_PAGES;
                  end
               end else if (!in_range) begin
                  rsp_data_in.status = pga_pkg::STAT_RANGE;
               end else if (cnt == '0) begin
                  rsp_data_in.status = pga_pkg::STAT_COUNT_ERR;
               end else begin
                  unique case (action_ff)
                     pga_pkg::ACT_RELEASE: begin
                        cnt_we                  = 1'b1;
                        cnt_wdata               = cnt - CNT_ONE;
                        rsp_data_in.result_page = page_ff;
                        if (cnt == CNT_ONE) begin
                           src_cmd.push              = 1'b1;
                           rsp_data_in.page_released = 1'b1;
                        end
                     end
                     pga_pkg::ACT_COW: begin
                        if (cnt == CNT_ONE) begin
                           rsp_data_in.result_page = page_ff;
                        end else if (src_stat.avail) begin
                           // new page now, old count in the next cycle
                           src_cmd.pop             = 1'b1;
                           cnt_we                  = 1'b1;
                           cnt_waddr               = take_page;
                           cnt_wdata               = CNT_ONE;
                           dec_cnt_in              = cnt - CNT_ONE;
                           rsp_data_in.result_page = pga_pkg::PAGE_WIDTH'(WW'(take_page));
                           rsp_data_in.copy_needed = 1'b1;
                           state_in                = STATE_FIN;
                        end else begin
                           rsp_data_in.status = pga_pkg::STAT_NO_PAGES;
                        end
                     end
                     pga_pkg::ACT_ADD_REF: begin
                        if (&cnt) begin
                           rsp_data_in.status = pga_pkg::STAT_COUNT_ERR;
                        end else begin
                           cnt_we                  = 1'b1;
                           cnt_wdata               = cnt + CNT_ONE;
                           rsp_data_in.result_page = page_ff;
                        end
                     end
                     default: begin
                        rsp_data_in = '0;
                     end
                  endcase
               end
            end
         end
         STATE_FIN: begin
            cnt_we    = 1'b1;
            cnt_wdata = dec_cnt_ff;
            state_in  = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         rsp_valid_ff  <= 1'b0;
         first_page_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            first_page_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_data.action;
         page_ff   <= req_data.page_index;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
      dec_cnt_ff <= dec_cnt_in;
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int PAGE_W = pga_pkg::PAGE_WIDTH;
   localparam int ACT_W = pga_pkg::ACTION_WIDTH;
   localparam int CNT_W = pga_pkg::COUNT_WIDTH_DEF;
   localparam int NUM_PAGES = pga_pkg::NUM_PAGES_DEF;
   localparam int COUNT_MAX = (1 << CNT_W) - 1;
   localparam logic [PAGE_W-1:0] PAGE_TOP = PAGE_W'(NUM_PAGES - 1);
   localparam logic [PAGE_W-1:0] PAGE_NEXT = PAGE_W'(NUM_PAGES - 2);
   localparam logic [PAGE_W-1:0] PAGE_BELOW = PAGE_W'(NUM_PAGES - 3);
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 6;
   localparam int RANDOM_PER_PHASE = 175;

   // A queued request; from_live asks the sender to name a page that is in use
   typedef struct packed {
      logic             from_live;
      pga_pkg::req_type rq;
   } req_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pga_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pga_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [PAGE_W-1:0] csr_wr_data = '0;

   // Allocator mirror: counts, free stack, fresh pointer, pages in use
   logic [CNT_W-1:0]  page_refs [NUM_PAGES];
   logic [PAGE_W-1:0] free_pages [$];
   logic [PAGE_W-1:0] live_pages [$];
   logic [PAGE_W-1:0] cfg_first_page = '0;
   int   fresh_next = NUM_PAGES - 1;
   bit   fresh_spent = 1'b0;

   req_entry_type    pending_reqs [$];
   pga_pkg::rsp_type expected_rsps [$];
   int   queued_count = 0;
   int   accepted_count = 0;
   int   fail_count = 0;
   int   idle_cycles = 0;
   bit   req_taken = 1'b0;
   bit   rsp_taken = 1'b0;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   send_gap_max = 4;
   int   recv_gap_max = 4;
   int   hold_asks = 0;
   int   hold_served = 0;
   int   hold_left = 0;

   page_allocator_refcount_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Pop the free stack, else hand out the next never-used page
   function automatic bit take_free_page(output logic [PAGE_W-1:0] pg);
      pg = '0;
      if (free_pages.size() != 0) begin
         pg = free_pages.pop_back();
         page_refs[pg] = CNT_W'(1);
         live_pages.push_back(pg);
         return 1'b1;
      end
      if (!fresh_spent && fresh_next >= int'(cfg_first_page)) begin
         pg = PAGE_W'(fresh_next);
         if (fresh_next == 0)
            fresh_spent = 1'b1;
         else
            fresh_next--;
         page_refs[pg] = CNT_W'(1);
         live_pages.push_back(pg);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Expected response of one request; updates the mirror
   function automatic pga_pkg::rsp_type predict_response(input pga_pkg::req_type rq);
      pga_pkg::rsp_type rs;
      logic [PAGE_W-1:0] new_page;
      int cnt;
      rs = '0;
      if (rq.action == pga_pkg::ACT_ALLOC) begin
         if (take_free_page(new_page))
            rs.result_page = new_page;
         else
            rs.status = pga_pkg::STAT_NO_PAGES;
      end else if (rq.page_index < cfg_first_page) begin
         // 15-bit index never reaches NUM_PAGES, so only the low bound matters
         rs.status = pga_pkg::STAT_RANGE;
      end else begin
         cnt = int'(page_refs[rq.page_index]);
         if (cnt == 0) begin
            rs.status = pga_pkg::STAT_COUNT_ERR;
         end else begin
            case (rq.action)
               pga_pkg::ACT_RELEASE: begin
                  cnt--;
                  page_refs[rq.page_index] = CNT_W'(cnt);
                  rs.result_page = rq.page_index;
                  if (cnt == 0) begin
                     if (free_pages.size() < NUM_PAGES)
                        free_pages.push_back(rq.page_index);
                     for (int i = 0; i < live_pages.size(); i++) begin
                        if (live_pages[i] == rq.page_index) begin
                           live_pages.delete(i);
                           break;
                        end
                     end
                     rs.page_released = 1'b1;
                  end
               end
               pga_pkg::ACT_COW: begin
                  if (cnt <= 1) begin
                     rs.result_page = rq.page_index;
                  end else if (take_free_page(new_page)) begin
                     page_refs[rq.page_index] = CNT_W'(cnt - 1);
                     rs.result_page = new_page;
                     rs.copy_needed = 1'b1;
                  end else begin
                     rs.status = pga_pkg::STAT_NO_PAGES;
                  end
               end
               default: begin
                  // add reference saturates at the count maximum
                  if (cnt >= COUNT_MAX) begin
                     rs.status = pga_pkg::STAT_COUNT_ERR;
                  end else begin
                     page_refs[rq.page_index] = CNT_W'(cnt + 1);
                     rs.result_page = rq.page_index;
                  end
               end
            endcase
         end
      end
      return rs;
   endfunction

   function automatic void queue_req(input logic [ACT_W-1:0] action,
                                     input logic [PAGE_W-1:0] page, input bit from_live);
      req_entry_type e;
      e.from_live = from_live;
      e.rq.action = action;
      e.rq.page_index = page;
      pending_reqs.push_back(e);
      queued_count++;
   endfunction

   task automatic set_first_page(input logic [PAGE_W-1:0] value);
      @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every queued request is taken and answered, then let the pipe settle
   task automatic wait_idle();
      do
         @(negedge clock);
      while (accepted_count != queued_count || expected_rsps.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Monitor: predict on request accept, check on response accept, watchdog
   always @(posedge clock) begin : monitor
      pga_pkg::rsp_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (reset) begin
         cfg_first_page = '0;
         for (int p = 0; p < NUM_PAGES; p++)
            page_refs[p] = '0;
         free_pages.delete();
         live_pages.delete();
         fresh_next = NUM_PAGES - 1;
         fresh_spent = 1'b0;
         idle_cycles = 0;
      end else begin
         if (csr_wr_en)
            cfg_first_page = csr_wr_data;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            accepted_count++;
            expected_rsps.push_back(predict_response(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: response with none expected, got page %0d status %0d",
                        $time, rsp_data.result_page, rsp_data.status);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.result_page !== want.result_page ||
                   rsp_data.status !== want.status ||
                   rsp_data.copy_needed !== want.copy_needed ||
                   rsp_data.page_released !== want.page_released) begin
                  fail_count++;
                  $display({"%0t: mismatch, expected page %0d status %0d copy %0b ",
                            "released %0b, got page %0d status %0d copy %0b released %0b"},
                           $time, want.result_page, want.status, want.copy_needed,
                           want.page_released, rsp_data.result_page, rsp_data.status,
                           rsp_data.copy_needed, rsp_data.page_released);
               end
            end
         end
         if (req_taken || rsp_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no request or response moved for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // Sender: one request at a time, random gap after each accepted one
   always @(negedge clock) begin : sender
      req_entry_type nxt;
      if (!reset) begin
         if (req_taken)
            send_wait = int'($urandom_range(0, send_gap_max));
         if (!req_valid || req_taken) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               // mirror is current here, so a live page is really in use
               if (nxt.from_live) begin
                  if (live_pages.size() == 0)
                     nxt.rq.action = pga_pkg::ACT_ALLOC;
                  else
                     nxt.rq.page_index = live_pages[$urandom_range(0, live_pages.size() - 1)];
               end
               req_data <= nxt.rq;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall per response, plus one long hold-off on demand
   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (hold_asks != hold_served) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
         end
         if (rsp_taken)
            recv_wait = int'($urandom_range(0, recv_gap_max));
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus: directed corner cases, then random phases under several settings
   initial begin : stimulus
      logic [PAGE_W-1:0] hot_page;
      int pick;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Two managed pages only: exhaustion, range, free-page and copy cases
      set_first_page(PAGE_NEXT);
      queue_req(pga_pkg::ACT_ALLOC, '0, 1'b0);
      queue_req(pga_pkg::ACT_ALLOC, PAGE_TOP, 1'b0);
      queue_req(pga_pkg::ACT_ALLOC, '0, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, '0, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, PAGE_BELOW, 1'b0);
      queue_req(pga_pkg::ACT_ADD_REF, PAGE_TOP, 1'b0);
      queue_req(pga_pkg::ACT_COW, PAGE_TOP, 1'b0);
      queue_req(pga_pkg::ACT_COW, PAGE_NEXT, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, PAGE_NEXT, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, PAGE_NEXT, 1'b0);
      queue_req(pga_pkg::ACT_ADD_REF, PAGE_NEXT, 1'b0);
      queue_req(pga_pkg::ACT_COW, PAGE_NEXT, 1'b0);
      queue_req(pga_pkg::ACT_COW, PAGE_TOP, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, PAGE_TOP, 1'b0);
      queue_req(pga_pkg::ACT_ALLOC, '0, 1'b0);
      queue_req(pga_pkg::ACT_ADD_REF, PAGE_TOP, 1'b0);
      wait_idle();

      // Highest first page: stack empty means no page; lower pages out of range
      set_first_page(PAGE_TOP);
      queue_req(pga_pkg::ACT_ALLOC, '0, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, PAGE_NEXT, 1'b0);
      queue_req(pga_pkg::ACT_RELEASE, PAGE_TOP, 1'b0);
      wait_idle();

      // Lowest first page: page zero is free, fresh pages resume
      set_first_page('0);
      queue_req(pga_pkg::ACT_RELEASE, '0, 1'b0);
      queue_req(pga_pkg::ACT_ADD_REF, '0, 1'b0);
      queue_req(pga_pkg::ACT_COW, '0, 1'b0);
      queue_req(pga_pkg::ACT_ALLOC, PAGE_TOP, 1'b0);
      queue_req(pga_pkg::ACT_COW, PAGE_NEXT, 1'b0);

      for (int ph = 0; ph < 5; ph++) begin
         wait_idle();
         send_gap_max = (ph % 2 == 0) ? 4 : 0;
         recv_gap_max = (ph == 3) ? 0 : 4;
         case (ph)
            0: set_first_page('0);
            1: set_first_page(PAGE_W'(PAGE_TOP - $urandom_range(100, 400)));
            2: set_first_page(PAGE_TOP);
            3: set_first_page(PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
            default: set_first_page('0);
         endcase
         if (ph == 1)
            hold_asks++;
         // drive one page's count to saturation and past it
         if (ph == 4) begin
            queue_req(pga_pkg::ACT_ALLOC, '0, 1'b0);
            wait_idle();
            if (live_pages.size() != 0) begin
               hot_page = live_pages[live_pages.size() - 1];
               repeat (COUNT_MAX + 1) queue_req(pga_pkg::ACT_ADD_REF, hot_page, 1'b0);
            end
         end
         // mostly well-formed use of pages in use, some noise on any page
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 28)
               queue_req(pga_pkg::ACT_ALLOC, PAGE_W'($urandom_range(0, NUM_PAGES - 1)), 1'b0);
            else if (pick < 50)
               queue_req(pga_pkg::ACT_RELEASE, '0, 1'b1);
            else if (pick < 64)
               queue_req(pga_pkg::ACT_COW, '0, 1'b1);
            else if (pick < 78)
               queue_req(pga_pkg::ACT_ADD_REF, '0, 1'b1);
            else if (pick < 90)
               queue_req(ACT_W'($urandom_range(0, 3)),
                         PAGE_W'(PAGE_TOP - $urandom_range(0, 700)), 1'b0);
            else
               queue_req(ACT_W'($urandom_range(0, 3)),
                         PAGE_W'($urandom_range(0, NUM_PAGES - 1)), 1'b0);
         end
      end
      wait_idle();

      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
